@@ rtl/bmpu_pkg.sv @@
// Shared types, constants and tables of the BMP pixel unpacker.
`default_nettype none

package bmpu_pkg;

	localparam int DATA_W     = 8;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 12;
	localparam int CH_W       = 8;
	localparam int OUT_W      = 56;
	localparam int WORD_W     = 32;
	localparam int HELD_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int BPP_W      = 3;
	localparam int DIM_W      = 13;
	localparam int MASK_W     = 16;
	localparam int TZ_W       = 4;
	localparam int NBITS_W    = 5;
	localparam int RECIP_W    = 24;
	localparam int PROD_W     = MASK_W + RECIP_W;
	localparam int NUM_CH     = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

	localparam logic [BPP_W-1:0]  BPP_MIN   = 3'd2;
	localparam logic [BPP_W-1:0]  BPP_RGB   = 3'd3;
	localparam logic [BPP_W-1:0]  BPP_MAX   = 3'd4;
	localparam logic [BPP_W-1:0]  BPP_RST   = 3'd3;
	localparam logic [DIM_W-1:0]  WIDTH_RST = 13'd1;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd1;
	localparam logic [MASK_W-1:0] RED_RST   = 16'h7C00;
	localparam logic [MASK_W-1:0] GREEN_RST = 16'h03E0;
	localparam logic [MASK_W-1:0] BLUE_RST  = 16'h001F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BPP        = 3'd0,
		REG_WIDTH      = 3'd1,
		REG_HEIGHT     = 3'd2,
		REG_BOTTOM_UP  = 3'd3,
		REG_RED_MASK   = 3'd4,
		REG_GREEN_MASK = 3'd5,
		REG_BLUE_MASK  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FMT_FIELDS = 2'd0,
		FMT_BGR    = 2'd1,
		FMT_BGRA   = 2'd2
	} fmt_t;

	typedef struct packed {
		logic [BPP_W-1:0]  bpp;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic              bottom_up;
		logic [MASK_W-1:0] red_mask;
		logic [MASK_W-1:0] green_mask;
		logic [MASK_W-1:0] blue_mask;
	} cfg_t;

	// One complete pixel handed from the front end to the back end.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		fmt_t              fmt;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              last;
	} pix_req_t;

	// ceil(255 * 4^n / (2^n - 1)): floor(f * this >> 2n) equals
	// floor(f * 255 / (2^n - 1)) exactly for every f below 2^n - 1.
	function automatic logic [RECIP_W-1:0] recip(input logic [NBITS_W-1:0] nbits);
		logic [RECIP_W-1:0] r;
		case (nbits)
			5'd1:    r = 24'd1020;
			5'd2:    r = 24'd1360;
			5'd3:    r = 24'd2332;
			5'd4:    r = 24'd4352;
			5'd5:    r = 24'd8424;
			5'd6:    r = 24'd16580;
			5'd7:    r = 24'd32898;
			5'd8:    r = 24'd65536;
			5'd9:    r = 24'd130816;
			5'd10:   r = 24'd261376;
			5'd11:   r = 24'd522496;
			5'd12:   r = 24'd1044736;
			5'd13:   r = 24'd2089216;
			5'd14:   r = 24'd4178176;
			5'd15:   r = 24'd8356096;
			5'd16:   r = 24'd16711936;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bmpu_front.sv @@
// Front end: byte assembly, row padding and pixel position counting.
`default_nettype none

module bmpu_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  bmpu_pkg::cfg_t                   cfg,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [bmpu_pkg::DATA_W-1:0]      in_byte,
	input  wire                              q_full,
	output logic                             push,
	output bmpu_pkg::pix_req_t               push_data
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RC   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WCMP = WW + 1;
	localparam int HCMP = HW + 1;
	localparam int CX   = (CW > bmpu_pkg::COL_W) ? CW : bmpu_pkg::COL_W;
	localparam int RX   = (HW > bmpu_pkg::ROW_W) ? HW : bmpu_pkg::ROW_W;

	logic [1:0]                    slot_q;
	logic [bmpu_pkg::HELD_W-1:0]   held_q;
	logic [1:0]                    pad_q;
	logic [CW-1:0]                 col_q;
	logic [RC-1:0]                 row_q;

	logic [bmpu_pkg::BPP_W-1:0]    bpp_eff;
	logic [WW-1:0]                 w_eff;
	logic [HW-1:0]                 h_eff;
	logic [bmpu_pkg::WORD_W-1:0]   word;
	logic                          accept;
	logic                          pix_done;
	logic [WCMP-1:0]               col_inc;
	logic [HCMP-1:0]               row_inc;
	logic                          col_wrap;
	logic                          row_wrap;
	logic [3:0]                    pad_prod;
	logic [1:0]                    pad_new;
	logic [RX-1:0]                 row_flip;
	logic [RX-1:0]                 row_x;
	logic [CX-1:0]                 col_x;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (cfg.bpp < bmpu_pkg::BPP_MIN) begin
			bpp_eff = bmpu_pkg::BPP_MIN;
		end else if (cfg.bpp > bmpu_pkg::BPP_MAX) begin
			bpp_eff = bmpu_pkg::BPP_MAX;
		end else begin
			bpp_eff = cfg.bpp;
		end
	end

	always_comb begin
		if (cfg.width == '0) begin
			w_eff = WW'(1);
		end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.width);
		end
	end

	always_comb begin
		if (cfg.height == '0) begin
			h_eff = HW'(1);
		end else if (32'(cfg.height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg.height);
		end
	end

	// The incoming byte lands in the lane that matches its place in the pixel.
	assign word     = {8'd0, held_q} | (32'(in_byte) << {slot_q, 3'b000});
	assign pix_done = (3'({1'b0, slot_q}) + 3'd1) >= bpp_eff;

	assign col_inc  = WCMP'(col_q) + WCMP'(1);
	assign row_inc  = HCMP'(row_q) + HCMP'(1);
	assign col_wrap = col_inc >= WCMP'(w_eff);
	assign row_wrap = row_inc >= HCMP'(h_eff);

	// Row pad is the distance of width * bytes-per-pixel to the next multiple of four.
	assign pad_prod = 4'(2'(w_eff)) * 4'(bpp_eff[1:0]);
	assign pad_new  = 2'(4'd0 - pad_prod);

	assign row_x    = RX'(row_q);
	assign col_x    = CX'(col_q);
	assign row_flip = RX'(h_eff) - RX'(1) - row_x;

	assign push = accept && (pad_q == 2'd0) && pix_done;

	always_comb begin
		push_data.word = word;
		push_data.row  = cfg.bottom_up ? row_flip[bmpu_pkg::ROW_W-1:0]
		                               : row_x[bmpu_pkg::ROW_W-1:0];
		push_data.col  = col_x[bmpu_pkg::COL_W-1:0];
		push_data.last = col_wrap && row_wrap;
		case (bpp_eff)
			bmpu_pkg::BPP_MIN: push_data.fmt = bmpu_pkg::FMT_FIELDS;
			bmpu_pkg::BPP_RGB: push_data.fmt = bmpu_pkg::FMT_BGR;
			default:           push_data.fmt = bmpu_pkg::FMT_BGRA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			held_q <= '0;
			pad_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end else if (!pix_done) begin
				held_q <= word[bmpu_pkg::HELD_W-1:0];
				slot_q <= slot_q + 2'd1;
			end else begin
				slot_q <= '0;
				held_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					pad_q <= pad_new;
					if (row_wrap) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + RC'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/bmpu_queue.sv @@
// Short first-in first-out queue of completed pixels between front and back end.
`default_nettype none

module bmpu_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  bmpu_pkg::pix_req_t  push_data,
	output logic                full,
	input  wire                 pop,
	output bmpu_pkg::pix_req_t  pop_data,
	output logic                empty
);

	bmpu_pkg::pix_req_t              entry_q [bmpu_pkg::QUEUE_DEPTH];
	logic [bmpu_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bmpu_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bmpu_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full     = count_q == bmpu_pkg::QCNT_W'(bmpu_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + bmpu_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + bmpu_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + bmpu_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - bmpu_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/bmpu_back.sv @@
// Back end: three-stage channel extraction and scaling with the output register.
`default_nettype none

module bmpu_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  bmpu_pkg::cfg_t                   cfg,
	input  wire                              in_valid,
	output logic                             pop,
	input  bmpu_pkg::pix_req_t               in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [bmpu_pkg::OUT_W-1:0]       out_data,
	output logic                             out_last
);

	localparam int SH_W = bmpu_pkg::NBITS_W + 1;

	function automatic logic [bmpu_pkg::TZ_W-1:0] trail_zeros(
		input logic [bmpu_pkg::MASK_W-1:0] m
	);
		logic [bmpu_pkg::TZ_W-1:0] t;
		t = '0;
		for (int i = bmpu_pkg::MASK_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				t = bmpu_pkg::TZ_W'(i);
			end
		end
		return t;
	endfunction

	// Per-channel constants derived from the masks, refreshed every cycle.
	logic [bmpu_pkg::MASK_W-1:0]  mask_in  [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::MASK_W-1:0]  mask_eff [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::NBITS_W-1:0] nb_in    [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::MASK_W-1:0]  mask_q   [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::TZ_W-1:0]    tz_q     [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::NBITS_W-1:0] nb_q     [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::MASK_W-1:0]  lim_q    [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::RECIP_W-1:0] rcp_q    [bmpu_pkg::NUM_CH];

	logic                         en;
	logic                         vld_s1, vld_s2, vld_s3;

	logic [bmpu_pkg::MASK_W-1:0]  field    [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::MASK_W-1:0]  field_s1 [bmpu_pkg::NUM_CH];
	logic                         sat_s1   [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::PROD_W-1:0]  prod_s2  [bmpu_pkg::NUM_CH];
	logic                         sat_s2   [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::PROD_W-1:0]  quot     [bmpu_pkg::NUM_CH];
	logic [bmpu_pkg::CH_W-1:0]    chan     [bmpu_pkg::NUM_CH];

	logic [bmpu_pkg::WORD_W-1:0]  word_s1, word_s2;
	bmpu_pkg::fmt_t               fmt_s1, fmt_s2;
	logic [bmpu_pkg::ROW_W-1:0]   row_s1, row_s2;
	logic [bmpu_pkg::COL_W-1:0]   col_s1, col_s2;
	logic                         last_s1, last_s2, last_s3;
	logic [bmpu_pkg::CH_W-1:0]    alpha;
	logic [bmpu_pkg::OUT_W-1:0]   data_s3;

	assign mask_in[0] = cfg.red_mask;
	assign mask_in[1] = cfg.green_mask;
	assign mask_in[2] = cfg.blue_mask;

	always_comb begin
		for (int c = 0; c < bmpu_pkg::NUM_CH; c++) begin
			mask_eff[c] = (mask_in[c] == '0) ? bmpu_pkg::MASK_W'(1) : mask_in[c];
			nb_in[c]    = bmpu_pkg::NBITS_W'($countones(mask_eff[c]));
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < bmpu_pkg::NUM_CH; c++) begin
			mask_q[c] <= mask_eff[c];
			tz_q[c]   <= trail_zeros(mask_eff[c]);
			nb_q[c]   <= nb_in[c];
			lim_q[c]  <= bmpu_pkg::MASK_W'((17'd1 << nb_in[c]) - 17'd1);
			rcp_q[c]  <= bmpu_pkg::recip(nb_in[c]);
		end
	end

	// The whole pipeline moves together; it holds only while a result waits.
	assign en  = !vld_s3 || out_ready;
	assign pop = en && in_valid;

	always_comb begin
		for (int c = 0; c < bmpu_pkg::NUM_CH; c++) begin
			field[c] = (in_data.word[bmpu_pkg::MASK_W-1:0] & mask_q[c]) >> tz_q[c];
		end
	end

	always_comb begin
		for (int c = 0; c < bmpu_pkg::NUM_CH; c++) begin
			quot[c] = prod_s2[c] >> SH_W'({nb_q[c], 1'b0});
			chan[c] = sat_s2[c] ? bmpu_pkg::CH_FULL : quot[c][bmpu_pkg::CH_W-1:0];
		end
		alpha = bmpu_pkg::CH_FULL;
		case (fmt_s2)
			bmpu_pkg::FMT_FIELDS: begin
			end
			bmpu_pkg::FMT_BGR: begin
				chan[0] = word_s2[23:16];
				chan[1] = word_s2[15:8];
				chan[2] = word_s2[7:0];
			end
			bmpu_pkg::FMT_BGRA: begin
				chan[0] = word_s2[23:16];
				chan[1] = word_s2[15:8];
				chan[2] = word_s2[7:0];
				alpha   = word_s2[31:24];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= in_data.word;
			fmt_s1  <= in_data.fmt;
			row_s1  <= in_data.row;
			col_s1  <= in_data.col;
			last_s1 <= in_data.last;
			for (int c = 0; c < bmpu_pkg::NUM_CH; c++) begin
				field_s1[c] <= field[c];
				sat_s1[c]   <= field[c] >= lim_q[c];
			end

			word_s2 <= word_s1;
			fmt_s2  <= fmt_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			for (int c = 0; c < bmpu_pkg::NUM_CH; c++) begin
				prod_s2[c] <= bmpu_pkg::PROD_W'(field_s1[c]) * bmpu_pkg::PROD_W'(rcp_q[c]);
				sat_s2[c]  <= sat_s1[c];
			end

			data_s3 <= {alpha, chan[2], chan[1], chan[0], col_s2, row_s2};
			last_s3 <= last_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = data_s3;
	assign out_last  = last_s3;

endmodule

`default_nettype wire

@@ rtl/bmp_pixel_unpacker.sv @@
// Top level of the BMP pixel unpacker: configuration registers and the front/back split.
`default_nettype none

// The unpacker takes the bytes of a BMP pixel array, one byte per request on
// the slave stream, row padding included, and gives one RGBA pixel per
// request on the master stream after the last byte of each pixel. Pixels of
// 2 bytes are split by the red, green and blue bitfield masks and each field
// is scaled to 8 bits as floor(field * 255 / (2^bits - 1)), saturating at
// 255; pixels of 3 bytes are B, G, R and of 4 bytes B, G, R, A. Alpha is 255
// unless the pixel has 4 bytes. Bottom-up images get their rows flipped, and
// tlast marks the final pixel of the image, after which the position
// counters start over. The input stream takes one byte every cycle while the
// four-entry pixel queue between the front end and the back end has room,
// so the sustained rate is one byte per clock; the front end counts bytes,
// pad and position and pushes a completed pixel into the queue in the
// same cycle as its last byte is taken; the pixel then passes three
// back-end stages (mask and shift, one 16x24 multiply per channel, final
// shift and saturate into the output register). Only a held result stalls
// the back end, and the front end keeps taking bytes until the queue
// fills. Configuration writes are taken in every cycle and must be made
// while no pixel is in flight; registers take effect at once and the
// position counters are kept.
module bmp_pixel_unpacker #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Configuration write channel: register index and write data.
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bmpu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [bmpu_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Byte stream in.
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [bmpu_pkg::DATA_W-1:0]         s_axis_tdata,  // [7:0] data_byte
	// Pixel stream out.
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [11:0] pixel_row, [23:12] pixel_col, [31:24] red, [39:32] green,
	// [47:40] blue, [55:48] alpha
	output logic [bmpu_pkg::OUT_W-1:0]          m_axis_tdata,
	output logic                                m_axis_tlast   // last_pixel
);

	bmpu_pkg::cfg_t     cfg_q;
	logic               q_push;
	bmpu_pkg::pix_req_t q_push_data;
	logic               q_full;
	logic               q_pop;
	bmpu_pkg::pix_req_t q_pop_data;
	logic               q_empty;

	// Register writes are never refused. An index past the last register is
	// accepted and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp        <= bmpu_pkg::BPP_RST;
			cfg_q.width      <= bmpu_pkg::WIDTH_RST;
			cfg_q.height     <= bmpu_pkg::HEIGHT_RST;
			cfg_q.bottom_up  <= 1'b1;
			cfg_q.red_mask   <= bmpu_pkg::RED_RST;
			cfg_q.green_mask <= bmpu_pkg::GREEN_RST;
			cfg_q.blue_mask  <= bmpu_pkg::BLUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (bmpu_pkg::cfg_reg_t'(cfg_index))
				bmpu_pkg::REG_BPP:        cfg_q.bpp        <= cfg_data[bmpu_pkg::BPP_W-1:0];
				bmpu_pkg::REG_WIDTH:      cfg_q.width      <= cfg_data[bmpu_pkg::DIM_W-1:0];
				bmpu_pkg::REG_HEIGHT:     cfg_q.height     <= cfg_data[bmpu_pkg::DIM_W-1:0];
				bmpu_pkg::REG_BOTTOM_UP:  cfg_q.bottom_up  <= cfg_data[0];
				bmpu_pkg::REG_RED_MASK:   cfg_q.red_mask   <= cfg_data;
				bmpu_pkg::REG_GREEN_MASK: cfg_q.green_mask <= cfg_data;
				bmpu_pkg::REG_BLUE_MASK:  cfg_q.blue_mask  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end assembles bytes into pixels, skips the row pad and tags
	// each pixel with its output position and its format.
	bmpu_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// The queue lets the front end keep taking bytes while a result waits.
	bmpu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	// The back end turns each queued pixel into 8-bit channels.
	bmpu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (!q_empty),
		.pop       (q_pop),
		.in_data   (q_pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/bmpu_checker.sv @@
// Port-level checks of the BMP pixel unpacker and their binding to the top level.
`default_nettype none

module bmpu_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_axis_tready,
	input wire                            m_axis_tvalid,
	input wire                            m_axis_tready,
	input wire [bmpu_pkg::OUT_W-1:0]      m_axis_tdata,
	input wire                            m_axis_tlast
);

	// A stalled result keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// A ready output in the previous cycle drains a queue entry, so the queue cannot be full.
	a_ready_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tready) |-> s_axis_tready)
		else $error("byte stream blocked although the output was draining");

	// No result is offered in the first cycle after reset.
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_axis_tvalid)
		else $error("result offered right after reset");

endmodule

bind bmp_pixel_unpacker bmpu_checker u_bmpu_checker (.*);

`default_nettype wire

@@ sim/bmp_pixel_unpacker_tb.sv @@
// Self-checking testbench for the BMP pixel unpacker: byte stream in, checked RGBA pixels out.

module bmp_pixel_unpacker_tb;
	import bmpu_pkg::*;

	localparam int MAX_DIM       = 4096;
	localparam int IDLE_PERCENT  = 13;
	localparam int DRAIN_CYCLES  = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_BYTES  = 1600;
	localparam int PHASE_BYTES   = 256;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_LIMIT  = 10;

	// Index 7 decodes to no register; writes to it must leave the block untouched.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// One expected pixel, laid out the way the output stream carries it.
	typedef struct {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  alpha;
		logic             last;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  m_axis_tlast;

	// Shadow copy of the configuration registers.
	logic [BPP_W-1:0]  cfg_bpp;
	logic [DIM_W-1:0]  cfg_width;
	logic [DIM_W-1:0]  cfg_height;
	logic              cfg_flip;
	logic [MASK_W-1:0] cfg_red_mask;
	logic [MASK_W-1:0] cfg_green_mask;
	logic [MASK_W-1:0] cfg_blue_mask;

	// Shadow copy of the byte-unpacking state.
	logic [1:0]        slot_cnt;
	logic [HELD_W-1:0] held;
	logic [COL_W-1:0]  col_cnt;
	logic [ROW_W-1:0]  row_cnt;
	logic [1:0]        pad_left;

	pixel_t pending_pixels[$];
	int     fail_count;
	int     cycle_count;
	logic   no_idle;
	logic   hold_req;
	int     hold_left;

	bmp_pixel_unpacker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Hard stop in case the block hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// Pixel size and image dimensions as the block uses them after clamping.
	function automatic int eff_bpp(input logic [BPP_W-1:0] bpp);
		if (bpp < BPP_MIN) return int'(BPP_MIN);
		if (bpp > BPP_MAX) return int'(BPP_MAX);
		return int'(bpp);
	endfunction

	function automatic int eff_dim(input logic [DIM_W-1:0] dim);
		if (dim == 0) return 1;
		if (dim > MAX_DIM) return MAX_DIM;
		return int'(dim);
	endfunction

	// Bitfield channel: mask, shift down, then floor(field * 255 / (2^bits - 1)).
	// A zero mask behaves as a one-bit mask at bit 0; scattered masks can push
	// the field past full scale, which saturates.
	function automatic logic [CH_W-1:0] channel_level(input logic [15:0] word,
			input logic [MASK_W-1:0] mask);
		logic [MASK_W-1:0] m;
		int                tz;
		int                nbits;
		int unsigned       field;
		int unsigned       level;
		m = (mask == '0) ? 16'h0001 : mask;
		tz = 0;
		while (!m[tz]) tz++;
		nbits = $countones(m);
		field = 32'(word & m) >> tz;
		level = (field * 255) / ((32'd1 << nbits) - 1);
		return (level > 255) ? CH_FULL : level[7:0];
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_BPP:        cfg_bpp = value[BPP_W-1:0];
			REG_WIDTH:      cfg_width = value[DIM_W-1:0];
			REG_HEIGHT:     cfg_height = value[DIM_W-1:0];
			REG_BOTTOM_UP:  cfg_flip = value[0];
			REG_RED_MASK:   cfg_red_mask = value;
			REG_GREEN_MASK: cfg_green_mask = value;
			REG_BLUE_MASK:  cfg_blue_mask = value;
			default: ;
		endcase
	endfunction

	// Advance the shadow state by one accepted byte and queue the pixel it
	// completes, if any.
	function automatic void unpack_byte(input logic [DATA_W-1:0] b);
		int            bpp;
		int            w;
		int            h;
		logic [31:0]   word;
		pixel_t        px;
		bpp = eff_bpp(cfg_bpp);
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		if (pad_left != 0) begin
			pad_left = pad_left - 1'b1;
			return;
		end
		if (int'(slot_cnt) + 1 < bpp) begin
			held = held | (HELD_W'(b) << (8 * slot_cnt));
			slot_cnt = slot_cnt + 1'b1;
			return;
		end
		word = {8'h00, held} | (32'(b) << (8 * slot_cnt));
		if (bpp == int'(BPP_MIN)) begin
			px.red = channel_level(word[15:0], cfg_red_mask);
			px.green = channel_level(word[15:0], cfg_green_mask);
			px.blue = channel_level(word[15:0], cfg_blue_mask);
			px.alpha = CH_FULL;
		end else begin
			px.blue = word[7:0];
			px.green = word[15:8];
			px.red = word[23:16];
			px.alpha = (bpp == int'(BPP_MAX)) ? word[31:24] : CH_FULL;
		end
		slot_cnt = '0;
		held = '0;
		// The flip is taken modulo the row field width, so a row count beyond
		// a freshly shrunk height wraps around.
		px.row = cfg_flip ? ROW_W'(h - 1 - int'(row_cnt)) : row_cnt;
		px.col = col_cnt;
		px.last = 1'b0;
		if (int'(col_cnt) + 1 >= w) begin
			col_cnt = '0;
			pad_left = 2'((4 - ((w * bpp) & 3)) & 3);
			if (int'(row_cnt) + 1 >= h) begin
				px.last = 1'b1;
				row_cnt = '0;
			end else begin
				row_cnt = row_cnt + 1'b1;
			end
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
		pending_pixels.push_back(px);
	endfunction

	function automatic void flag_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	task automatic check_pixel();
		pixel_t want;
		if (pending_pixels.size() == 0) begin
			flag_mismatch("unexpected pixel, data", 0, int'(m_axis_tdata[31:0]));
			return;
		end
		want = pending_pixels.pop_front();
		if (m_axis_tdata[11:0] !== want.row)
			flag_mismatch("pixel_row", want.row, m_axis_tdata[11:0]);
		if (m_axis_tdata[23:12] !== want.col)
			flag_mismatch("pixel_col", want.col, m_axis_tdata[23:12]);
		if (m_axis_tdata[31:24] !== want.red)
			flag_mismatch("red", want.red, m_axis_tdata[31:24]);
		if (m_axis_tdata[39:32] !== want.green)
			flag_mismatch("green", want.green, m_axis_tdata[39:32]);
		if (m_axis_tdata[47:40] !== want.blue)
			flag_mismatch("blue", want.blue, m_axis_tdata[47:40]);
		if (m_axis_tdata[55:48] !== want.alpha)
			flag_mismatch("alpha", want.alpha, m_axis_tdata[55:48]);
		if (m_axis_tlast !== want.last)
			flag_mismatch("last_pixel", want.last, m_axis_tlast);
	endtask

	// Every pixel request that the output accepts is checked against the
	// oldest expected pixel.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_pixel();
	end

	// Output side: random stalls, a no-stall mode, and a long hold-off that a
	// test can ask for. The hold-off is counted here so that the sender keeps
	// offering bytes while the output is blocked.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else if (no_idle) begin
			m_axis_tready = 1'b1;
		end else begin
			m_axis_tready = ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// One byte request on the input stream. The valid stays high on return so
	// that back-to-back calls in no-idle mode run at full rate; drain_pipe and write_reg drop it.
	task automatic send_byte(input logic [DATA_W-1:0] b);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		do @(posedge clk); while (!s_axis_tready);
		unpack_byte(b);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait for every expected pixel, then a further DRAIN_CYCLES wait, since pad and
	// partial-pixel bytes leave no result to wait for.
	task automatic drain_pipe();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [MASK_W-1:0] pick_mask();
		int lo;
		int len;
		case ($urandom_range(9))
			0: return '0;
			1: return 16'hFFFF;
			2: return MASK_W'($urandom);
			default: begin
				lo = $urandom_range(15);
				len = $urandom_range(16 - lo, 1);
				return MASK_W'(((32'd1 << len) - 1) << lo);
			end
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim(input int small_max);
		case ($urandom_range(19))
			0: return '0;
			1: return DIM_W'($urandom_range(8191, MAX_DIM));
			2: return DIM_W'($urandom_range(24, small_max + 1));
			default: return DIM_W'($urandom_range(small_max, 1));
		endcase
	endfunction

	// Reset configuration: one 3-byte BGR pixel, one pad byte, flipped single row.
	task automatic test_reset_format();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'hA5);
	endtask

	// Four-byte pixels carry their own alpha; two flipped rows.
	task automatic test_bgra_flip();
		drain_pipe();
		write_reg(REG_BPP, {13'h1FFF, BPP_MAX});
		write_reg(REG_WIDTH, 16'd1);
		write_reg(REG_HEIGHT, 16'd2);
		write_reg(REG_BOTTOM_UP, 16'hFFFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Sixteen-bit pixels with a too-small pixel size, a zero mask, a full mask
	// and a scattered mask that saturates.
	task automatic test_bitfield_masks();
		drain_pipe();
		write_reg(REG_BPP, 16'd1);
		write_reg(REG_WIDTH, 16'd2);
		write_reg(REG_HEIGHT, 16'd1);
		write_reg(REG_RED_MASK, 16'h0000);
		write_reg(REG_GREEN_MASK, 16'hFFFF);
		write_reg(REG_BLUE_MASK, 16'h8001);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
	endtask

	// Zero width acts as one, an oversized height clamps to the maximum, so the
	// flipped rows start at the top of the row field.
	task automatic test_dimension_clamp();
		drain_pipe();
		write_reg(REG_BPP, {13'd0, BPP_RGB});
		write_reg(REG_WIDTH, 16'hE000);
		write_reg(REG_HEIGHT, 16'h1FFF);
		write_reg(REG_BOTTOM_UP, 16'd1);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Registers changed between pixels of an image: the counters stay, so a
	// shrunk height wraps the flipped row and ends the image at once, and a
	// shrunk pixel size finishes a half-collected pixel early.
	task automatic test_register_rewrite();
		drain_pipe();
		write_reg(REG_HEIGHT, 16'd1);
		write_reg(REG_SPARE, 16'hFFFF);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		send_byte(8'h78);
		drain_pipe();
		write_reg(REG_BPP, {13'd0, BPP_MAX});
		send_byte(8'hC3);
		send_byte(8'h3C);
		drain_pipe();
		write_reg(REG_BPP, {13'd0, BPP_MIN});
		send_byte(8'h99);
		send_byte(8'h01);
		send_byte(8'hFE);
	endtask

	// A long stretch with neither side idling.
	task automatic test_full_rate();
		drain_pipe();
		write_reg(REG_BPP, {13'd0, BPP_MAX});
		write_reg(REG_WIDTH, 16'd5);
		write_reg(REG_HEIGHT, 16'd6);
		write_reg(REG_BOTTOM_UP, 16'd0);
		no_idle = 1'b1;
		repeat (120) send_byte(DATA_W'($urandom));
		drain_pipe();
		no_idle = 1'b0;
	endtask

	// The output holds off while bytes keep coming, so the pixel queue fills
	// and the input has to stall.
	task automatic test_backpressure();
		drain_pipe();
		write_reg(REG_BPP, {13'd0, BPP_RGB});
		write_reg(REG_WIDTH, 16'd4);
		write_reg(REG_HEIGHT, 16'd4);
		write_reg(REG_BOTTOM_UP, 16'd1);
		no_idle = 1'b1;
		hold_req = 1'b1;
		repeat (48) send_byte(DATA_W'($urandom));
		drain_pipe();
		no_idle = 1'b0;
	endtask

	// Random settings, each followed mostly by whole images of random bytes and
	// sometimes by a cut-off image that leaves the counters mid-stream.
	task automatic test_random_images();
		int               sent;
		int               n;
		int               row_bytes;
		int               img;
		logic [BPP_W-1:0] bpp;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			drain_pipe();
			case ($urandom_range(9))
				0: bpp = BPP_W'($urandom_range(7));
				1, 2, 3: bpp = BPP_MIN;
				4, 5, 6: bpp = BPP_RGB;
				default: bpp = BPP_MAX;
			endcase
			w = pick_dim(6);
			h = pick_dim(4);
			write_reg(REG_BPP, {13'($urandom), bpp});
			write_reg(REG_WIDTH, {3'($urandom), w});
			write_reg(REG_HEIGHT, {3'($urandom), h});
			write_reg(REG_BOTTOM_UP, 16'($urandom));
			write_reg(REG_RED_MASK, pick_mask());
			write_reg(REG_GREEN_MASK, pick_mask());
			write_reg(REG_BLUE_MASK, pick_mask());
			if ($urandom_range(7) == 0)
				write_reg(REG_SPARE, 16'($urandom));
			row_bytes = eff_dim(w) * eff_bpp(bpp);
			img = eff_dim(h) * ((row_bytes + 3) / 4 * 4);
			n = img;
			if ($urandom_range(9) == 0)
				n = $urandom_range(img, 1);
			if (n > PHASE_BYTES)
				n = $urandom_range(PHASE_BYTES, 64);
			repeat (n) send_byte(DATA_W'($urandom));
			sent += n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BPP;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		fail_count = 0;
		cycle_count = 0;
		cfg_bpp = BPP_RST;
		cfg_width = WIDTH_RST;
		cfg_height = HEIGHT_RST;
		cfg_flip = 1'b1;
		cfg_red_mask = RED_RST;
		cfg_green_mask = GREEN_RST;
		cfg_blue_mask = BLUE_RST;
		slot_cnt = '0;
		held = '0;
		col_cnt = '0;
		row_cnt = '0;
		pad_left = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_format();
		test_bgra_flip();
		test_bitfield_masks();
		test_dimension_clamp();
		test_register_rewrite();
		test_full_rate();
		test_backpressure();
		test_random_images();
		drain_pipe();

		if (fail_count == 0 && pending_pixels.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bmpu_pkg.sv
rtl/bmpu_front.sv
rtl/bmpu_queue.sv
rtl/bmpu_back.sv
rtl/bmp_pixel_unpacker.sv
rtl/bmpu_checker.sv
sim/bmp_pixel_unpacker_tb.sv
